### sv/slcq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcq_pkg
// Shared sizes, codes and types for the serial line command queue.
// ----------------------------------------------------------------------------
package slcq_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int LINE_LEN    = 16;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int POS_W  = $clog2(LINE_LEN + 1);

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_CR = 8'd13;

    localparam logic [7:0] CH_FWD   = 8'h66;   // 'f'
    localparam logic [7:0] CH_BACK  = 8'h62;   // 'b'
    localparam logic [7:0] CH_LEFT  = 8'h6C;   // 'l'
    localparam logic [7:0] CH_RIGHT = 8'h72;   // 'r'
    localparam logic [7:0] CH_STOP  = 8'h73;   // 's'

    localparam logic [7:0] DIR_FWD   = 8'h46;  // 'F'
    localparam logic [7:0] DIR_BACK  = 8'h62;  // 'b'
    localparam logic [7:0] DIR_LEFT  = 8'h72;  // 'r'
    localparam logic [7:0] DIR_RIGHT = 8'h4C;  // 'L'
    localparam logic [7:0] DIR_STOP  = 8'h53;  // 'S'

    localparam logic [9:0] AMT_STRAIGHT = 10'd500;
    localparam logic [9:0] AMT_TURN     = 10'd700;
    localparam logic [6:0] SPD_STRAIGHT = 7'd48;
    localparam logic [6:0] SPD_TURN     = 7'd68;

    typedef enum logic [2:0] {
        EV_STORED  = 3'd0,
        EV_IGNORED = 3'd1,
        EV_LINE    = 3'd2,
        EV_FULL    = 3'd3,
        EV_CMD     = 3'd4,
        EV_EMPTY   = 3'd5,
        EV_UNKNOWN = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_FWD   = 3'd1,
        ACT_BACK  = 3'd2,
        ACT_LEFT  = 3'd3,
        ACT_RIGHT = 3'd4,
        ACT_STOP  = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        OP_CHAR = 2'd0,
        OP_TERM = 2'd1,
        OP_PROC = 2'd2
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } head_t;

endpackage

### sv/serial_line_command_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_line_command_queue_core
// Serial byte line assembler with a first-char ring and command decoder.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// input   | in_valid / in_stall | kind, rx_byte
// output  | out_valid/out_stall | event_res, action, drive_amount,
//         |                     | direction_code, speed_code, queued_lines
//
// One word per cycle sustained while out_stall is low; each word makes exactly one result word.
// Each word passes through the two-word command queue and then the back
// end's output register; the back end's ring pointer update is a feedback loop.
// Reset clears the ring, pointers and line position at once; no sweep.
// in_stall rises when the command queue holds two words; out_stall holds
// the output register and backs up into that queue.
module serial_line_command_queue_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [2:0] action,
    output logic [9:0] drive_amount,
    output logic [7:0] direction_code,
    output logic [6:0] speed_code,
    output logic [2:0] queued_lines
);
    import slcq_pkg::*;

    head_t head;
    logic  pop;

    slcq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .rx_byte  (rx_byte),
        .head     (head),
        .pop      (pop)
    );

    slcq_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .action         (action),
        .drive_amount   (drive_amount),
        .direction_code (direction_code),
        .speed_code     (speed_code),
        .queued_lines   (queued_lines)
    );

endmodule

### sv/slcq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcq_front
// Accepts input words, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module slcq_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [7:0]         rx_byte,
    output slcq_pkg::head_t    head,
    input  logic               pop
);
    import slcq_pkg::*;

    cmd_t                mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    logic                push;
    logic                do_pop;
    cmd_t                cls;

    always_comb
    begin
        cls.data = rx_byte;
        if (kind)
            cls.op = OP_PROC;
        else if (rx_byte == CH_LF || rx_byte == CH_CR)
            cls.op = OP_TERM;
        else
            cls.op = OP_CHAR;
    end

    assign in_stall   = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign push       = in_valid && !in_stall;
    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= cls;
    end

endmodule

### sv/slcq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcq_back
// Executes queued words against the line ring and registers one result each.
// ----------------------------------------------------------------------------
module slcq_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  slcq_pkg::head_t    head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         event_res,
    output logic [2:0]         action,
    output logic [9:0]         drive_amount,
    output logic [7:0]         direction_code,
    output logic [6:0]         speed_code,
    output logic [2:0]         queued_lines
);
    import slcq_pkg::*;

    logic [7:0]        first_chars_reg [QUEUE_DEPTH];
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0] read_slot_reg, read_slot_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              fc_we;
    logic [7:0]        fc_wdata;

    logic              out_valid_reg, out_valid_next;
    event_t            ev_reg, ev_next;
    action_t           act_reg, act_next;
    logic [9:0]        amt_reg, amt_next;
    logic [7:0]        dir_reg, dir_next;
    logic [6:0]        spd_reg, spd_next;
    logic [2:0]        ql_reg, ql_next;

    logic              fire;
    logic              ring_full;
    logic              ring_empty;
    logic [7:0]        oldest;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [2:0] waiting(input logic [SLOT_W-1:0] w,
                                           input logic [SLOT_W-1:0] r);
        logic [SLOT_W:0] d;
        if (w >= r)
            d = {1'b0, w} - {1'b0, r};
        else
            d = {1'b0, w} + (SLOT_W + 1)'(QUEUE_DEPTH) - {1'b0, r};
        return 3'(d);
    endfunction

    assign fire       = head.valid && (!out_valid_reg || !out_stall);
    assign pop        = fire;
    assign ring_full  = (next_slot(write_slot_reg) == read_slot_reg);
    assign ring_empty = (read_slot_reg == write_slot_reg);
    assign oldest     = first_chars_reg[read_slot_reg];

    always_comb
    begin
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        pos_next        = pos_reg;
        fc_we           = 1'b0;
        fc_wdata        = head.cmd.data;
        ev_next         = EV_STORED;
        act_next        = ACT_NONE;
        amt_next        = '0;
        dir_next        = '0;
        spd_next        = '0;
        case (head.cmd.op)
            OP_CHAR:
            begin
                if (ring_full)
                    ev_next = EV_FULL;
                else if (pos_reg >= POS_W'(LINE_LEN))
                    ev_next = EV_IGNORED;
                else
                begin
                    fc_we    = (pos_reg == '0);
                    pos_next = pos_reg + 1'b1;
                    ev_next  = EV_STORED;
                end
            end
            OP_TERM:
            begin
                if (ring_full)
                    ev_next = EV_FULL;
                else
                begin
                    // empty line leaves a zero first char
                    fc_we           = (pos_reg == '0);
                    fc_wdata        = '0;
                    pos_next        = '0;
                    write_slot_next = next_slot(write_slot_reg);
                    ev_next         = EV_LINE;
                end
            end
            OP_PROC:
            begin
                if (ring_empty)
                    ev_next = EV_EMPTY;
                else
                begin
                    read_slot_next = next_slot(read_slot_reg);
                    ev_next        = EV_CMD;
                    case (oldest)
                        CH_FWD:
                        begin
                            act_next = ACT_FWD;
                            amt_next = AMT_STRAIGHT;
                            dir_next = DIR_FWD;
                            spd_next = SPD_STRAIGHT;
                        end
                        CH_BACK:
                        begin
                            act_next = ACT_BACK;
                            amt_next = AMT_STRAIGHT;
                            dir_next = DIR_BACK;
                            spd_next = SPD_STRAIGHT;
                        end
                        CH_LEFT:
                        begin
                            act_next = ACT_LEFT;
                            amt_next = AMT_TURN;
                            dir_next = DIR_LEFT;
                            spd_next = SPD_TURN;
                        end
                        CH_RIGHT:
                        begin
                            act_next = ACT_RIGHT;
                            amt_next = AMT_TURN;
                            dir_next = DIR_RIGHT;
                            spd_next = SPD_TURN;
                        end
                        CH_STOP:
                        begin
                            act_next = ACT_STOP;
                            dir_next = DIR_STOP;
                        end
                        default:
                            ev_next = EV_UNKNOWN;
                    endcase
                end
            end
            default:
                ev_next = EV_STORED;
        endcase
        ql_next = waiting(write_slot_next, read_slot_next);
    end

    always_comb
    begin
        if (fire)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            pos_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                first_chars_reg[i] <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                write_slot_reg <= write_slot_next;
                read_slot_reg  <= read_slot_next;
                pos_reg        <= pos_next;
                if (fc_we)
                    first_chars_reg[write_slot_reg] <= fc_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ev_reg  <= ev_next;
            act_reg <= act_next;
            amt_reg <= amt_next;
            dir_reg <= dir_next;
            spd_reg <= spd_next;
            ql_reg  <= ql_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = ev_reg;
    assign action         = act_reg;
    assign drive_amount   = amt_reg;
    assign direction_code = dir_reg;
    assign speed_code     = spd_reg;
    assign queued_lines   = ql_reg;

endmodule

### sv/slcq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcq_checker
// Port-level checks on the serial line command queue core.
// ----------------------------------------------------------------------------
module slcq_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       kind,
    input logic [7:0] rx_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] event_res,
    input logic [2:0] action,
    input logic [9:0] drive_amount,
    input logic [7:0] direction_code,
    input logic [6:0] speed_code,
    input logic [2:0] queued_lines
);
    import slcq_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(kind) && $stable(rx_byte))
        else $error("input word dropped or changed under stall");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res)
            && $stable(queued_lines))
        else $error("result dropped or changed under stall");

    a_no_cmd_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_CMD |->
            action == ACT_NONE && drive_amount == 10'd0
            && direction_code == 8'd0 && speed_code == 7'd0)
        else $error("command fields set without a command");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_EMPTY |-> queued_lines == 3'd0)
        else $error("empty queue reported with lines waiting");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_FULL |-> queued_lines == 3'(QUEUE_DEPTH - 1))
        else $error("ring full reported below capacity");

endmodule

bind serial_line_command_queue_core slcq_checker u_slcq_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for serial_line_command_queue_core. A directed table
// walks the ring from empty to full and back through every command, then
// random command lines, broken lines and noise are sent with random gaps and
// output stalls. Each result word is checked against a fixed table word or a
// bit-accurate model of the line assembler, first-char ring and command decoder.
// ----------------------------------------------------------------------------
module tb;
    import slcq_pkg::*;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_PROC = 1'b1;
    localparam int RANDOM_WORDS = 850;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        event_t     ev;
        action_t    act;
        logic [9:0] amount;
        logic [7:0] dir;
        logic [6:0] speed;
        logic [2:0] lines;
    } result_t;

    typedef struct {
        logic       kind;
        logic [7:0] data;
        bit         fixed;
        result_t    want;
    } row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = KIND_BYTE;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] event_res;
    logic [2:0] action;
    logic [9:0] drive_amount;
    logic [7:0] direction_code;
    logic [6:0] speed_code;
    logic [2:0] queued_lines;

    // model state
    logic [7:0] slot_char [QUEUE_DEPTH];
    int         wr_slot;
    int         rd_slot;
    int         line_pos;

    result_t    pending_results [$];
    row_t       rows [$];
    int         errors = 0;
    int         words_sent = 0;
    bit         in_burst = 1'b0;
    bit         out_burst = 1'b0;

    serial_line_command_queue_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .action         (action),
        .drive_amount   (drive_amount),
        .direction_code (direction_code),
        .speed_code     (speed_code),
        .queued_lines   (queued_lines)
    );

    always #10 clk = ~clk;

    function automatic result_t res(input event_t e, input action_t a,
                                    input logic [9:0] amt, input logic [7:0] d,
                                    input logic [6:0] s, input logic [2:0] n);
        result_t r;
        r.ev     = e;
        r.act    = a;
        r.amount = amt;
        r.dir    = d;
        r.speed  = s;
        r.lines  = n;
        return r;
    endfunction

    function automatic result_t line_event(input logic k, input logic [7:0] b);
        result_t r;
        r = res(EV_STORED, ACT_NONE, '0, '0, '0, '0);
        if (k == KIND_BYTE)
        begin
            if ((wr_slot + 1) % QUEUE_DEPTH == rd_slot)
                r.ev = EV_FULL;  // ring full: position untouched, even on a terminator
            else if (b == CH_LF || b == CH_CR)
            begin
                if (line_pos == 0)
                    slot_char[wr_slot] = 8'h00;
                line_pos = 0;
                wr_slot  = (wr_slot + 1) % QUEUE_DEPTH;
                r.ev     = EV_LINE;
            end
            else if (line_pos >= LINE_LEN)
                r.ev = EV_IGNORED;
            else
            begin
                if (line_pos == 0)
                    slot_char[wr_slot] = b;
                line_pos++;
            end
        end
        else
        begin
            if (rd_slot == wr_slot)
                r.ev = EV_EMPTY;
            else
            begin
                r.ev = EV_CMD;
                case (slot_char[rd_slot])
                    CH_FWD:   r = res(EV_CMD, ACT_FWD, AMT_STRAIGHT, DIR_FWD, SPD_STRAIGHT, '0);
                    CH_BACK:  r = res(EV_CMD, ACT_BACK, AMT_STRAIGHT, DIR_BACK, SPD_STRAIGHT, '0);
                    CH_LEFT:  r = res(EV_CMD, ACT_LEFT, AMT_TURN, DIR_LEFT, SPD_TURN, '0);
                    CH_RIGHT: r = res(EV_CMD, ACT_RIGHT, AMT_TURN, DIR_RIGHT, SPD_TURN, '0);
                    CH_STOP:  r = res(EV_CMD, ACT_STOP, '0, DIR_STOP, '0, '0);
                    default:  r.ev = EV_UNKNOWN;
                endcase
                rd_slot = (rd_slot + 1) % QUEUE_DEPTH;
            end
        end
        r.lines = 3'((wr_slot + QUEUE_DEPTH - rd_slot) % QUEUE_DEPTH);
        return r;
    endfunction

    task automatic add_row(input logic k, input logic [7:0] d, input bit fixed,
                           input result_t want);
        row_t r;
        r.kind  = k;
        r.data  = d;
        r.fixed = fixed;
        r.want  = want;
        rows.push_back(r);
    endtask

    // Returns at the edge where the word is taken; in_valid stays high.
    task automatic send_word(input logic k, input logic [7:0] b, input bit fixed,
                             input result_t want);
        int      gap;
        result_t pred;
        gap = in_burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 31) == 0)
            in_burst = !in_burst;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        pred = line_event(k, b);
        pending_results.push_back(fixed ? want : pred);
        words_sent++;
    endtask

    // result side
    initial
    begin
        int      hold;
        result_t got;
        result_t want;
        forever
        begin
            hold = out_burst ? 0 : $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0)
                out_burst = !out_burst;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            // out_valid is unknown until the first reset edge
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            got = res(event_t'(event_res), action_t'(action), drive_amount,
                      direction_code, speed_code, queued_lines);
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected word: ev=%0d act=%0d amt=%0d dir=%h spd=%0d n=%0d",
                             got.ev, got.act, got.amount, got.dir, got.speed, got.lines);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("word mismatch: exp ev=%0d act=%0d amt=%0d dir=%h spd=%0d n=%0d",
                                 want.ev, want.act, want.amount, want.dir, want.speed,
                                 want.lines);
                        $display("               got ev=%0d act=%0d amt=%0d dir=%h spd=%0d n=%0d",
                                 got.ev, got.act, got.amount, got.dir, got.speed,
                                 got.lines);
                    end
                end
            end
        end
    end

    initial
    begin
        logic [7:0] cmd_chars [5];
        result_t    none;
        int         proc_pct;
        int         len;
        logic [7:0] b;
        bit         broken;

        cmd_chars = '{CH_FWD, CH_BACK, CH_LEFT, CH_RIGHT, CH_STOP};
        none      = res(EV_STORED, ACT_NONE, '0, '0, '0, '0);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            slot_char[i] = 8'h00;
        wr_slot  = 0;
        rd_slot  = 0;
        line_pos = 0;

        // fill the ring with one line per command, an empty line and an
        // unknown line, hit the full ring, then drain it past empty
        add_row(KIND_PROC, 8'hFF, 1, res(EV_EMPTY, ACT_NONE, '0, '0, '0, 3'd0));
        add_row(KIND_BYTE, CH_FWD, 0, none);
        add_row(KIND_BYTE, CH_LF, 0, none);
        add_row(KIND_BYTE, CH_BACK, 0, none);
        add_row(KIND_BYTE, CH_CR, 0, none);
        add_row(KIND_BYTE, CH_LEFT, 0, none);
        add_row(KIND_BYTE, CH_LF, 0, none);
        add_row(KIND_BYTE, CH_RIGHT, 0, none);
        add_row(KIND_BYTE, CH_LF, 0, none);
        add_row(KIND_BYTE, CH_STOP, 0, none);
        add_row(KIND_BYTE, CH_LF, 0, none);
        add_row(KIND_BYTE, CH_LF, 0, none);
        add_row(KIND_BYTE, 8'hFF, 0, none);
        add_row(KIND_BYTE, CH_CR, 0, none);
        add_row(KIND_BYTE, 8'h61, 1, res(EV_FULL, ACT_NONE, '0, '0, '0, 3'd7));
        add_row(KIND_BYTE, CH_LF, 1, res(EV_FULL, ACT_NONE, '0, '0, '0, 3'd7));
        add_row(KIND_PROC, 8'h00, 1,
                res(EV_CMD, ACT_FWD, AMT_STRAIGHT, DIR_FWD, SPD_STRAIGHT, 3'd6));
        add_row(KIND_PROC, 8'h00, 1,
                res(EV_CMD, ACT_BACK, AMT_STRAIGHT, DIR_BACK, SPD_STRAIGHT, 3'd5));
        add_row(KIND_PROC, 8'h00, 1,
                res(EV_CMD, ACT_LEFT, AMT_TURN, DIR_LEFT, SPD_TURN, 3'd4));
        add_row(KIND_PROC, 8'h00, 1,
                res(EV_CMD, ACT_RIGHT, AMT_TURN, DIR_RIGHT, SPD_TURN, 3'd3));
        add_row(KIND_PROC, 8'h00, 1, res(EV_CMD, ACT_STOP, '0, DIR_STOP, '0, 3'd2));
        add_row(KIND_PROC, 8'h00, 0, none);
        add_row(KIND_PROC, 8'h00, 0, none);
        add_row(KIND_PROC, 8'hFF, 1, res(EV_EMPTY, ACT_NONE, '0, '0, '0, 3'd0));
        add_row(KIND_BYTE, 8'h00, 0, none);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_word(rows[i].kind, rows[i].data, rows[i].fixed, rows[i].want);

        proc_pct = 35;
        while (words_sent < rows.size() + RANDOM_WORDS)
        begin
            // shift the balance so the ring both fills up and drains
            if ($urandom_range(0, 15) == 0)
                case ($urandom_range(0, 2))
                    0:       proc_pct = 15;
                    1:       proc_pct = 35;
                    default: proc_pct = 60;
                endcase
            if ($urandom_range(0, 99) < 8)
                send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 0, none);
            else if ($urandom_range(0, 99) < proc_pct)
                send_word(KIND_PROC, 8'($urandom_range(0, 255)), 0, none);
            else
            begin
                broken = ($urandom_range(0, 19) == 0);
                if ($urandom_range(0, 19) == 0)
                    len = 0;
                else if ($urandom_range(0, 9) == 0)
                    len = $urandom_range(LINE_LEN - 2, LINE_LEN + 4);
                else
                    len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++)
                begin
                    if (i == 0 && $urandom_range(0, 9) < 7)
                        b = cmd_chars[$urandom_range(0, 4)];
                    else
                        b = 8'($urandom_range(0, 255));
                    send_word(KIND_BYTE, b, 0, none);
                end
                if (!broken)
                    send_word(KIND_BYTE, $urandom_range(0, 1) ? CH_LF : CH_CR, 0, none);
            end
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
sv/slcq_pkg.sv
sv/slcq_front.sv
sv/slcq_back.sv
sv/serial_line_command_queue_core.sv
sv/slcq_checker.sv
sim/tb.sv
